>>> rtl/blmf_pkg.sv
// Shared types, codes and constants of the breathing LED mode fader.
package blmf_pkg;

   localparam int unsigned SINE_ENTRIES_DEF = 256;

   localparam logic [15:0] FLOOR_LEVEL = 16'd9830;
   localparam logic [16:0] SPAN_LEVEL  = 17'd55705;
   localparam logic [16:0] UNIT_Q16    = 17'd65536;
   localparam logic [16:0] HALF_Q16    = 17'd32768;
   localparam logic [11:0] MAX_FADE_MS = 12'd4095;
   localparam logic [11:0] PEND_ON_MS  = 12'd1500;
   localparam logic [18:0] PULSE_MS    = 19'd500;

   localparam logic REQ_TICK = 1'b0;
   localparam logic REQ_MODE = 1'b1;

   localparam logic CSR_IDX_TRANSITION = 1'b0;
   localparam logic [11:0] TRANSITION_RESET = 12'd500;

   typedef enum logic [1:0] {
      MODE_STOPPED = 2'd0,
      MODE_IDLE    = 2'd1,
      MODE_RUNNING = 2'd2,
      MODE_PENDING = 2'd3
   } mode_type;

   localparam logic [7:0] MODE_RGB [4][3] = '{
      '{8'd231, 8'd130, 8'd132},
      '{8'd205, 8'd214, 8'd244},
      '{8'd140, 8'd170, 8'd238},
      '{8'd220, 8'd138, 8'd120}
   };

   localparam logic [18:0] MODE_PER    [4] = '{19'd1, 19'd4000, 19'd1800, 19'd3000};
   localparam logic [18:0] MODE_PER3   [4] = '{19'd3, 19'd12000, 19'd5400, 19'd9000};
   localparam logic [18:0] MODE_PER23  [4] = '{19'd23, 19'd92000, 19'd41400, 19'd69000};
   localparam logic [18:0] MODE_PER75  [4] = '{19'd75, 19'd300000, 19'd135000, 19'd225000};
   localparam logic [18:0] MODE_PER109 [4] = '{19'd109, 19'd436000, 19'd196200, 19'd327000};

   localparam int unsigned DIV_NUM_W = 36;
   localparam int unsigned DIV_DEN_W = 19;
   localparam int unsigned DIV_Q_W   = 17;
   localparam int unsigned DIV_CNT_W = $clog2(DIV_Q_W + 1);

   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_ADV,
      OP_SEL,
      OP_CDIV,
      OP_CSQ,
      OP_CSPAN,
      OP_CLV,
      OP_KDIV,
      OP_TARGET,
      OP_K2,
      OP_K3,
      OP_KS,
      OP_BA,
      OP_BB,
      OP_BC,
      OP_OUT
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [1:0] chan;
   } cmd_type;

   typedef struct packed {
      logic flat;
      logic blend;
      logic div_busy;
   } status_type;

endpackage

>>> rtl/blmf_req_if.sv
// Request channel interface of the breathing LED mode fader.
interface blmf_req_if;
   logic       valid;
   logic       ready;
   logic       req_type;
   logic [9:0] delta_ms;
   logic [1:0] target_mode;

   modport source (output valid, req_type, delta_ms, target_mode, input ready);
   modport sink (input valid, req_type, delta_ms, target_mode, output ready);
endinterface

>>> rtl/blmf_rsp_if.sv
// Response channel interface of the breathing LED mode fader.
interface blmf_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] brightness;
   logic [7:0]  red;
   logic [7:0]  green;
   logic [7:0]  blue;
   logic [1:0]  mode_now;
   logic        fading;

   modport source (output valid, brightness, red, green, blue, mode_now, fading, input ready);
   modport sink (input valid, brightness, red, green, blue, mode_now, fading, output ready);
endinterface

>>> rtl/breathing_led_mode_fader_unit.sv
// Top level of the breathing LED mode fader.
// Each request transaction is a time tick or a mode change and yields one response
// transaction with brightness (Q0.16), colour, mode and fading flag. A mode change
// goes straight to the output state, which registers the response once the previous
// one is taken. Two 17-bit-quotient divisions on the shared restoring divider
// (curve position, fade fraction) dominate a tick, followed by the shared multiplier
// for the curve, the smoothstep weight and eight blend products; ticks in a flat
// part of the curve or outside a crossfade skip the matching division. One
// transaction is in work at a time; the next is accepted while the previous response
// waits. The crossfade length register sits at byte address 0 of the APB port.
module breathing_led_mode_fader_unit #(
   parameter int unsigned SINE_TABLE_ENTRIES = blmf_pkg::SINE_ENTRIES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   blmf_req_if.sink          req_ch,
   blmf_rsp_if.source        rsp_ch,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [2:0]        csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);
   import blmf_pkg::*;

   cmd_type     cmd;
   status_type  status;
   logic        csr_hit;
   logic        csr_wr;
   logic [11:0] transition_ms;

   assign csr_hit    = csr_paddr[2] == CSR_IDX_TRANSITION;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_hit;
   assign csr_pready = 1'b1;
   assign csr_prdata = csr_hit ? {20'b0, transition_ms} : '0;

   blmf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_type  (req_ch.req_type),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   blmf_dp #(
      .SINE_TABLE_ENTRIES (SINE_TABLE_ENTRIES)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_type      (req_ch.req_type),
      .delta_ms      (req_ch.delta_ms),
      .target_mode   (req_ch.target_mode),
      .csr_wr        (csr_wr),
      .csr_wdata     (csr_pwdata[11:0]),
      .transition_ms (transition_ms),
      .brightness    (rsp_ch.brightness),
      .red           (rsp_ch.red),
      .green         (rsp_ch.green),
      .blue          (rsp_ch.blue),
      .mode_now      (rsp_ch.mode_now),
      .fading        (rsp_ch.fading)
   );
endmodule

>>> rtl/blmf_div.sv
// Shared restoring divider, one quotient bit per cycle.
module blmf_div (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [blmf_pkg::DIV_NUM_W-1:0]      num,
   input  logic [blmf_pkg::DIV_DEN_W-1:0]      den,
   output logic                                busy,
   output logic [blmf_pkg::DIV_Q_W-1:0]        quot
);
   import blmf_pkg::*;

   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [DIV_Q_W-1:0]   bits_ff, bits_in;
   logic [DIV_Q_W-1:0]   quot_ff, quot_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic [DIV_DEN_W:0]   trial;
   logic [DIV_DEN_W:0]   diff;
   logic                 take;

   assign trial = {rem_ff, bits_ff[DIV_Q_W-1]};
   assign take  = trial >= {1'b0, den_ff};
   assign diff  = trial - {1'b0, den_ff};

   always_comb begin
      rem_in  = rem_ff;
      den_in  = den_ff;
      bits_in = bits_ff;
      quot_in = quot_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         rem_in  = num[DIV_NUM_W-1:DIV_Q_W];
         den_in  = den;
         bits_in = num[DIV_Q_W-1:0];
         cnt_in  = DIV_CNT_W'(DIV_Q_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = take ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
         bits_in = {bits_ff[DIV_Q_W-2:0], 1'b0};
         quot_in = {quot_ff[DIV_Q_W-2:0], take};
         cnt_in  = cnt_ff - 1'b1;
         busy_in = cnt_ff != DIV_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      bits_ff <= bits_in;
      quot_ff <= quot_in;
   end

   assign busy = busy_ff;
   assign quot = quot_ff;
endmodule

>>> rtl/blmf_dp.sv
// Datapath: animation state, curve and crossfade arithmetic, output register.
module blmf_dp #(
   parameter int unsigned SINE_TABLE_ENTRIES = blmf_pkg::SINE_ENTRIES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  blmf_pkg::cmd_type     cmd,
   output blmf_pkg::status_type  status,
   input  logic                  req_type,
   input  logic [9:0]            delta_ms,
   input  logic [1:0]            target_mode,
   input  logic                  csr_wr,
   input  logic [11:0]           csr_wdata,
   output logic [11:0]           transition_ms,
   output logic [15:0]           brightness,
   output logic [7:0]            red,
   output logic [7:0]            green,
   output logic [7:0]            blue,
   output logic [1:0]            mode_now,
   output logic                  fading
);
   import blmf_pkg::*;

   localparam int unsigned IW = $clog2(SINE_TABLE_ENTRIES + 1);
   localparam longint unsigned HALF_ENTRIES = SINE_TABLE_ENTRIES / 2;

   typedef logic [16:0] sine_tab_type [0:SINE_TABLE_ENTRIES];
   typedef enum logic [1:0] {RG_FLAT, RG_RISE, RG_FALL, RG_PEND} region_type;

   function automatic longint unsigned const_div(longint unsigned n, longint unsigned d);
      longint unsigned q, r;
      q = '0;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
         r = {r[62:0], n[b]};
         if (r >= d) begin
            r    = r - d;
            q[b] = 1'b1;
         end
      end
      return q;
   endfunction

   function automatic sine_tab_type build_sine();
      sine_tab_type    tab;
      longint unsigned th, th2, term, acc, s;
      for (int i = 0; i <= SINE_TABLE_ENTRIES; i++) begin
         th  = const_div(64'd1686629713 * longint'(i) + HALF_ENTRIES,
                         longint'(SINE_TABLE_ENTRIES));
         th2 = (th * th) >> 30;
         term = th;
         acc  = th;
         for (int k = 1; k <= 6; k++) begin
            term = const_div((term * th2) >> 30, longint'((2 * k) * (2 * k + 1)));
            if (k[0]) acc = (term > acc) ? 64'd0 : acc - term;
            else acc = acc + term;
         end
         s = (acc * 64'd65536 + (64'd1 << 29)) >> 30;
         tab[i] = (s > 64'd65536) ? 17'd65536 : s[16:0];
      end
      return tab;
   endfunction

   localparam sine_tab_type SineTab = build_sine();

   logic [11:0] trans_ff;
   logic [1:0]  mode_ff;
   logic [11:0] phase_ff;
   logic [11:0] fade_ff;
   logic        fade_act_ff;
   logic [15:0] start_lvl_ff;
   logic [7:0]  start_rgb_ff [3];
   logic [15:0] level_ff;
   logic [7:0]  rgb_ff [3];
   logic [9:0]  delta_ff;

   region_type  region_ff;
   logic [8:0]  l_ff;
   logic [15:0] tl_ff;
   logic [48:0] prod_ff;
   logic [31:0] acc_ff;
   logic [31:0] k2_ff;
   logic [16:0] ks_ff;

   logic [15:0] out_lvl_ff;
   logic [7:0]  out_r_ff, out_g_ff, out_b_ff;
   logic [1:0]  out_mode_ff;
   logic        out_fade_ff;

   region_type  region_c;
   logic [8:0]  l_c;
   logic [16:0] p25;
   logic [12:0] psum;
   logic [11:0] phase_next;
   logic [12:0] fsum;
   logic        div_start;
   logic [19:0] div_a;
   logic [DIV_DEN_W-1:0] div_den;
   logic        div_busy;
   logic [DIV_Q_W-1:0] quot;
   logic [16:0] xc, wv, qv, qsel;
   logic [IW+17:0] sidx_prod;
   logic [IW+1:0]  sidx_raw;
   logic [IW-1:0]  sidx;
   logic [16:0] s_val, y_c;
   logic [31:0] mul_a;
   logic [16:0] mul_b;
   logic        mul_en;
   logic [32:0] lv_sum;
   logic [15:0] lv_c;
   logic [50:0] ks_sum;
   logic [15:0] b_start, b_target;
   logic [32:0] b_sum;

   // curve region of the current phase
   assign p25 = 17'(phase_ff) * 17'd25;
   always_comb begin
      region_c = RG_FLAT;
      case (mode_ff)
         MODE_IDLE, MODE_RUNNING: begin
            if ({4'b0, phase_ff, 3'b0} < MODE_PER3[mode_ff]) region_c = RG_RISE;
            else if ({2'b0, p25} < MODE_PER23[mode_ff]) region_c = RG_FALL;
         end
         MODE_PENDING: begin
            if (phase_ff < PEND_ON_MS) region_c = RG_PEND;
         end
         default: region_c = RG_FLAT;
      endcase
   end

   always_comb begin
      if (phase_ff >= 12'd1000) l_c = 9'(phase_ff - 12'd1000);
      else if (phase_ff >= 12'd500) l_c = 9'(phase_ff - 12'd500);
      else l_c = phase_ff[8:0];
   end

   assign psum = {1'b0, phase_ff} + {3'b0, delta_ff};
   always_comb begin
      if (mode_ff == MODE_STOPPED) phase_next = '0;
      else if (psum >= MODE_PER[mode_ff][12:0])
         phase_next = 12'(psum - MODE_PER[mode_ff][12:0]);
      else phase_next = psum[11:0];
   end
   assign fsum = {1'b0, fade_ff} + {3'b0, delta_ff};

   // divider operands
   assign div_start = (cmd.op == OP_CDIV) || (cmd.op == OP_KDIV);
   always_comb begin
      div_a   = {8'b0, fade_ff};
      div_den = DIV_DEN_W'(trans_ff);
      if (cmd.op == OP_CDIV) begin
         case (region_ff)
            RG_RISE: begin
               div_a   = {5'b0, phase_ff, 3'b0};
               div_den = MODE_PER3[mode_ff];
            end
            RG_FALL: begin
               div_a   = 20'(phase_ff) * 20'd200 - 20'(MODE_PER75[mode_ff]);
               div_den = MODE_PER109[mode_ff];
            end
            RG_PEND: begin
               div_a   = {11'b0, l_ff};
               div_den = PULSE_MS;
            end
            default: begin
               div_a   = '0;
               div_den = PULSE_MS;
            end
         endcase
      end
   end

   blmf_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   ({div_a, 16'b0}),
      .den   (div_den),
      .busy  (div_busy),
      .quot  (quot)
   );

   // sine table lookup
   assign xc   = (quot > UNIT_Q16) ? UNIT_Q16 : quot;
   assign wv   = UNIT_Q16 - xc;
   assign qv   = (quot <= HALF_Q16) ? {quot[15:0], 1'b0}
                                    : {(UNIT_Q16[15:0] - quot[15:0]), 1'b0};
   assign qsel = (region_ff == RG_PEND) ? qv : xc;
   assign sidx_prod = (IW+18)'(qsel) * (IW+18)'(SINE_TABLE_ENTRIES) + (IW+18)'(HALF_Q16);
   assign sidx_raw  = sidx_prod[IW+17:16];
   assign sidx = (sidx_raw > (IW+2)'(SINE_TABLE_ENTRIES)) ? IW'(SINE_TABLE_ENTRIES)
                                                            : sidx_raw[IW-1:0];
   assign s_val = SineTab[sidx];

   assign y_c = (region_ff == RG_PEND) ? s_val : 17'((prod_ff + 49'(HALF_Q16)) >> 16);

   assign lv_sum = 33'(FLOOR_LEVEL) + 33'((prod_ff + 49'(HALF_Q16)) >> 16);
   assign lv_c   = (lv_sum > 33'd65535) ? 16'hFFFF : lv_sum[15:0];

   assign ks_sum = 51'({k2_ff, 16'b0}) + 51'({k2_ff, 17'b0}) - 51'({prod_ff, 1'b0})
                 + (51'd1 << 31);

   // blend channel select
   always_comb begin
      case (cmd.chan)
         2'd0: begin
            b_start  = start_lvl_ff;
            b_target = tl_ff;
         end
         2'd1: begin
            b_start  = {8'b0, start_rgb_ff[0]};
            b_target = {8'b0, MODE_RGB[mode_ff][0]};
         end
         2'd2: begin
            b_start  = {8'b0, start_rgb_ff[1]};
            b_target = {8'b0, MODE_RGB[mode_ff][1]};
         end
         default: begin
            b_start  = {8'b0, start_rgb_ff[2]};
            b_target = {8'b0, MODE_RGB[mode_ff][2]};
         end
      endcase
   end
   assign b_sum = {1'b0, acc_ff} + {1'b0, prod_ff[31:0]} + 33'(HALF_Q16);

   // shared multiplier operands
   always_comb begin
      mul_en = 1'b1;
      mul_a  = '0;
      mul_b  = '0;
      case (cmd.op)
         OP_CSQ: begin
            mul_a = (region_ff == RG_RISE) ? 32'(s_val) : 32'(wv);
            mul_b = (region_ff == RG_RISE) ? s_val : wv;
         end
         OP_CSPAN: begin
            mul_a = 32'(y_c);
            mul_b = SPAN_LEVEL;
         end
         OP_K2: begin
            mul_a = 32'(quot[15:0]);
            mul_b = {1'b0, quot[15:0]};
         end
         OP_K3: begin
            mul_a = prod_ff[31:0];
            mul_b = {1'b0, quot[15:0]};
         end
         OP_BA: begin
            mul_a = 32'(b_start);
            mul_b = UNIT_Q16 - ks_ff;
         end
         OP_BB: begin
            mul_a = 32'(b_target);
            mul_b = ks_ff;
         end
         default: mul_en = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         trans_ff     <= TRANSITION_RESET;
         mode_ff      <= MODE_STOPPED;
         phase_ff     <= '0;
         fade_ff      <= '0;
         fade_act_ff  <= 1'b0;
         start_lvl_ff <= FLOOR_LEVEL;
         start_rgb_ff <= MODE_RGB[0];
         level_ff     <= FLOOR_LEVEL;
         rgb_ff       <= MODE_RGB[0];
      end else begin
         if (csr_wr) trans_ff <= csr_wdata;
         case (cmd.op)
            OP_LOAD: begin
               if (req_type == REQ_MODE && !(target_mode == mode_ff && !fade_act_ff)) begin
                  start_lvl_ff <= level_ff;
                  start_rgb_ff <= rgb_ff;
                  mode_ff      <= target_mode;
                  phase_ff     <= '0;
                  fade_ff      <= '0;
                  fade_act_ff  <= 1'b1;
               end
            end
            OP_ADV: begin
               phase_ff <= phase_next;
               if (fade_act_ff) fade_ff <= fsum[12] ? MAX_FADE_MS : fsum[11:0];
            end
            OP_TARGET: begin
               fade_act_ff <= 1'b0;
               level_ff    <= tl_ff;
               rgb_ff      <= MODE_RGB[mode_ff];
            end
            OP_BC: begin
               case (cmd.chan)
                  2'd0:    level_ff  <= b_sum[31:16];
                  2'd1:    rgb_ff[0] <= b_sum[23:16];
                  2'd2:    rgb_ff[1] <= b_sum[23:16];
                  default: rgb_ff[2] <= b_sum[23:16];
               endcase
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_LOAD) delta_ff <= delta_ms;
      if (cmd.op == OP_SEL) begin
         region_ff <= region_c;
         l_ff      <= l_c;
         tl_ff     <= FLOOR_LEVEL;
      end
      if (cmd.op == OP_CLV) tl_ff <= lv_c;
      if (mul_en) prod_ff <= mul_a * mul_b;
      if (cmd.op == OP_K3) k2_ff <= prod_ff[31:0];
      if (cmd.op == OP_KS) ks_ff <= ks_sum[48:32];
      if (cmd.op == OP_BB) acc_ff <= prod_ff[31:0];
      if (cmd.op == OP_OUT) begin
         out_lvl_ff  <= level_ff;
         out_r_ff    <= rgb_ff[0];
         out_g_ff    <= rgb_ff[1];
         out_b_ff    <= rgb_ff[2];
         out_mode_ff <= mode_ff;
         out_fade_ff <= fade_act_ff;
      end
   end

   assign status.flat     = region_c == RG_FLAT;
   assign status.blend    = fade_act_ff && (fade_ff < trans_ff);
   assign status.div_busy = div_busy;

   assign transition_ms = trans_ff;
   assign brightness    = out_lvl_ff;
   assign red           = out_r_ff;
   assign green         = out_g_ff;
   assign blue          = out_b_ff;
   assign mode_now      = out_mode_ff;
   assign fading        = out_fade_ff;
endmodule

>>> rtl/blmf_ctrl.sv
// Controller: handshakes and the step sequence of one transaction.
module blmf_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_type,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  blmf_pkg::status_type  status,
   output blmf_pkg::cmd_type     cmd
);
   import blmf_pkg::*;

   typedef enum logic [16:0] {
      ST_IDLE  = 17'h00001,
      ST_ADV   = 17'h00002,
      ST_SEL   = 17'h00004,
      ST_CDIV  = 17'h00008,
      ST_CDIVW = 17'h00010,
      ST_CSQ   = 17'h00020,
      ST_CSPAN = 17'h00040,
      ST_CLV   = 17'h00080,
      ST_FCHK  = 17'h00100,
      ST_KDIVW = 17'h00200,
      ST_K2    = 17'h00400,
      ST_K3    = 17'h00800,
      ST_KS    = 17'h01000,
      ST_BA    = 17'h02000,
      ST_BB    = 17'h04000,
      ST_BC    = 17'h08000,
      ST_OUT   = 17'h10000
   } state_type;

   state_type  state_ff, state_in;
   logic [1:0] chan_ff, chan_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      chan_in      = chan_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd.op       = OP_NONE;
      cmd.chan     = chan_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = (req_type == REQ_TICK) ? ST_ADV : ST_OUT;
            end
         end
         ST_ADV: begin
            cmd.op   = OP_ADV;
            state_in = ST_SEL;
         end
         ST_SEL: begin
            cmd.op   = OP_SEL;
            state_in = status.flat ? ST_FCHK : ST_CDIV;
         end
         ST_CDIV: begin
            cmd.op   = OP_CDIV;
            state_in = ST_CDIVW;
         end
         ST_CDIVW: begin
            if (!status.div_busy) state_in = ST_CSQ;
         end
         ST_CSQ: begin
            cmd.op   = OP_CSQ;
            state_in = ST_CSPAN;
         end
         ST_CSPAN: begin
            cmd.op   = OP_CSPAN;
            state_in = ST_CLV;
         end
         ST_CLV: begin
            cmd.op   = OP_CLV;
            state_in = ST_FCHK;
         end
         ST_FCHK: begin
            if (status.blend) begin
               cmd.op   = OP_KDIV;
               state_in = ST_KDIVW;
            end else begin
               cmd.op   = OP_TARGET;
               state_in = ST_OUT;
            end
         end
         ST_KDIVW: begin
            if (!status.div_busy) state_in = ST_K2;
         end
         ST_K2: begin
            cmd.op   = OP_K2;
            state_in = ST_K3;
         end
         ST_K3: begin
            cmd.op   = OP_K3;
            state_in = ST_KS;
         end
         ST_KS: begin
            cmd.op   = OP_KS;
            chan_in  = '0;
            state_in = ST_BA;
         end
         ST_BA: begin
            cmd.op   = OP_BA;
            state_in = ST_BB;
         end
         ST_BB: begin
            cmd.op   = OP_BB;
            state_in = ST_BC;
         end
         ST_BC: begin
            cmd.op   = OP_BC;
            chan_in  = chan_ff + 2'd1;
            state_in = (chan_ff == 2'd3) ? ST_OUT : ST_BA;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.op       = OP_OUT;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         chan_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         chan_ff      <= chan_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = state_ff == ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
endmodule

>>> rtl/blmf_chk.sv
// Port-level checker of the breathing LED mode fader and its bind.
module blmf_chk (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] brightness,
   input logic [7:0]  red,
   input logic [7:0]  green,
   input logic [7:0]  blue,
   input logic [1:0]  mode_now,
   input logic        fading
);
   import blmf_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped before it was taken");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while a transaction is in work");

   a_floor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> brightness >= FLOOR_LEVEL)
      else $error("brightness below floor");

   a_stopped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !fading && mode_now == MODE_STOPPED |->
         brightness == FLOOR_LEVEL && red == MODE_RGB[0][0] &&
         green == MODE_RGB[0][1] && blue == MODE_RGB[0][2])
      else $error("stopped mode shows wrong level or colour");
endmodule

bind breathing_led_mode_fader_unit blmf_chk u_chk (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_ch.valid),
   .req_ready  (req_ch.ready),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .brightness (rsp_ch.brightness),
   .red        (rsp_ch.red),
   .green      (rsp_ch.green),
   .blue       (rsp_ch.blue),
   .mode_now   (rsp_ch.mode_now),
   .fading     (rsp_ch.fading)
);
